/* src/dfr_pkg.sv */
// Package for the descending fractional rank unit.
// Holds the channel payload types, the job flags and the register map constants.
// No dependencies; every other file but dfr_stream_if imports it.
package dfr_pkg;

  localparam int VALUE_FIELD_W = 64;
  localparam int RANK_W        = 17;
  localparam int LEN_W         = 16;
  localparam int CFG_W         = 16;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [PADDR_W-1:0] ADDR_COLUMN_LENGTH  = 3'd0;
  localparam logic [CFG_W-1:0]   COLUMN_LENGTH_RESET = 16'd1;

  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_times_two;
    logic [LEN_W-1:0]  run_length;
    logic              column_end;
  } out_item_t;

  // What one accepted value leaves for the back end to report.
  typedef struct packed {
    logic close_run;
    logic final_run;
  } job_flags_t;

endpackage

/* src/dfr_stream_if.sv */
// Valid/ready stream channel used on both sides of the rank unit.
// The payload type is given by the instantiating testbench or parent.
interface dfr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/dfr_front.sv */
// Front end of the rank unit: tracks column position, previous value and run start,
// and turns each accepted value into a job when a run closes. Uses dfr_pkg.
module dfr_front
  import dfr_pkg::*;
#(
  parameter int VALUE_WIDTH    = 64,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [VALUE_WIDTH-1:0]    value,
  input  logic [CFG_W-1:0]          column_length,
  output logic                      push,
  output job_flags_t                job_flags,
  output logic [POSITION_WIDTH-1:0] job_len,
  output logic [POSITION_WIDTH-1:0] job_start,
  output logic [POSITION_WIDTH-1:0] job_pos
);

  localparam int PW = POSITION_WIDTH;
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;

  logic [VALUE_WIDTH-1:0] previous_value;
  logic [PW-1:0]          position;
  logic [PW-1:0]          run_start;
  logic [PW-1:0]          position_next;
  logic [PW-1:0]          run_start_next;

  logic [CW-1:0] len_cfg_wide;
  logic [CW-1:0] pos_max_wide;
  logic [CW-1:0] m_wide;
  logic [PW-1:0] m;
  logic [PW:0]   pos_inc;
  logic          close_run;
  logic          final_run;

  // Effective column length: zero means one, and it is clamped to the position range.
  always_comb begin
    len_cfg_wide = CW'(column_length);
    pos_max_wide = CW'({PW{1'b1}});
    if (column_length == '0) begin
      m_wide = CW'(1);
    end else if (len_cfg_wide > pos_max_wide) begin
      m_wide = pos_max_wide;
    end else begin
      m_wide = len_cfg_wide;
    end
    m = m_wide[PW-1:0];
  end

  always_comb begin
    pos_inc   = {1'b0, position} + (PW+1)'(1);
    close_run = (position != '0) && (value != previous_value);
    final_run = pos_inc >= {1'b0, m};
    // A length lowered in mid-column stretches the ranking length to cover this value.
    job_len   = (pos_inc > {1'b0, m}) ? pos_inc[PW-1:0] : m;
    job_start = run_start;
    job_pos   = position;
    job_flags.close_run = close_run;
    job_flags.final_run = final_run;
    push      = accept && (close_run || final_run);

    run_start_next = run_start;
    if (position == '0) begin
      run_start_next = '0;
    end else if (close_run) begin
      run_start_next = position;
    end
    position_next = pos_inc[PW-1:0];
    if (final_run) begin
      run_start_next = '0;
      position_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value <= '0;
      position       <= '0;
      run_start      <= '0;
    end else if (accept) begin
      previous_value <= value;
      position       <= position_next;
      run_start      <= run_start_next;
    end
  end

  a_start_zero_at_column_head: assert property (@(posedge clk) disable iff (rst)
    position == '0 |-> run_start == '0)
    else $error("run start is not zero at the head of a column");

  a_start_not_past_position: assert property (@(posedge clk) disable iff (rst)
    run_start <= position)
    else $error("run start lies beyond the column position");

  a_column_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && final_run |=> position == '0)
    else $error("position did not return to zero after the column end");

endmodule

/* src/dfr_queue.sv */
// Small job queue between the front and back ends of the rank unit.
// Register storage with a head that is visible without a read cycle. Uses dfr_pkg.
module dfr_queue
  import dfr_pkg::*;
#(
  parameter int WIDTH = 50,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] ptr);
    ptr_step = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_step(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_step(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* src/dfr_back.sv */
// Back end of the rank unit: turns queued jobs into result transactions and
// holds them in an output register. A job with two closed runs yields two results. Uses dfr_pkg.
module dfr_back
  import dfr_pkg::*;
#(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  job_flags_t                head_flags,
  input  logic [POSITION_WIDTH-1:0] head_len,
  input  logic [POSITION_WIDTH-1:0] head_start,
  input  logic [POSITION_WIDTH-1:0] head_pos,
  output logic                      pop,
  input  logic                      out_ready,
  output logic                      out_valid,
  output out_item_t                 out_item
);

  localparam int PW = POSITION_WIDTH;
  localparam int AW = ((PW + 2) > RANK_W) ? PW + 2 : RANK_W;

  logic      phase;
  logic      phase_next;
  logic      can_load;
  logic      load;
  logic      emit_close;
  logic [AW-1:0] s_wide;
  logic [AW-1:0] e_wide;
  logic [AW-1:0] rank_wide;
  logic [AW-1:0] count_wide;
  out_item_t item_next;

  assign can_load = !out_valid || out_ready;
  assign load     = head_valid && can_load;

  always_comb begin
    // The closed run goes out first; the final run of the column follows.
    emit_close = head_flags.close_run && !phase;
    if (emit_close) begin
      s_wide = AW'(head_start);
      e_wide = AW'(head_pos) - AW'(1);
    end else begin
      s_wide = head_flags.close_run ? AW'(head_pos) : AW'(head_start);
      e_wide = AW'(head_pos);
    end
    rank_wide  = (AW'(head_len) << 1) - s_wide - e_wide;
    count_wide = e_wide - s_wide + AW'(1);
    item_next.rank_times_two = rank_wide[RANK_W-1:0];
    item_next.run_length     = count_wide[LEN_W-1:0];
    item_next.column_end     = !emit_close;

    pop        = load && !(emit_close && head_flags.final_run);
    phase_next = phase;
    if (load) begin
      phase_next = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_phase_has_job: assert property (@(posedge clk) disable iff (rst)
    phase |-> head_valid)
    else $error("second result pending without a queued job");

  a_phase_from_double: assert property (@(posedge clk) disable iff (rst)
    $rose(phase) |-> $past(head_flags.close_run && head_flags.final_run))
    else $error("second result pending for a job with one closed run");

  a_double_splits: assert property (@(posedge clk) disable iff (rst)
    load && emit_close && head_flags.final_run |=> phase)
    else $error("job with two closed runs was retired after one result");

endmodule

/* src/descending_fractional_rank_unit.sv */
// Descending fractional rank unit. Values of a column stream in on "sample", one
// transaction per cycle, and each run of adjacent equal values yields one transaction
// on "result": twice its mean descending rank, its length, and a column end flag on
// the last run of the column. An item is accepted every cycle while the two-entry job
// queue has room; the last value of a column that also closes the run before it
// produces two results, which the output stage sends one after the other. The column
// length register sits at APB address 0 and should be written only while idle.
// Depends on dfr_pkg, dfr_stream_if, dfr_front, dfr_queue and dfr_back.
module descending_fractional_rank_unit
  import dfr_pkg::*;
#(
  parameter int VALUE_WIDTH    = 64,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  dfr_stream_if.sink           sample,
  dfr_stream_if.source         result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int PW    = POSITION_WIDTH;
  localparam int JOB_W = $bits(job_flags_t) + 3 * PW;

  logic [CFG_W-1:0] column_length;
  logic             accept;
  logic             push;
  job_flags_t       job_flags;
  logic [PW-1:0]    job_len;
  logic [PW-1:0]    job_start;
  logic [PW-1:0]    job_pos;
  logic             q_full;
  logic             head_valid;
  logic [JOB_W-1:0] head_data;
  job_flags_t       head_flags;
  logic [PW-1:0]    head_len;
  logic [PW-1:0]    head_start;
  logic [PW-1:0]    head_pos;
  logic             pop;
  in_item_t         sample_item;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_COLUMN_LENGTH) begin
      prdata = PDATA_W'(column_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_length <= COLUMN_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_COLUMN_LENGTH) begin
      column_length <= pwdata[CFG_W-1:0];
    end
  end

  assign sample_item  = sample.payload;
  assign sample.ready = !q_full;
  assign accept       = sample.valid && !q_full;

  dfr_front #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .value         (sample_item.value[VALUE_WIDTH-1:0]),
    .column_length (column_length),
    .push          (push),
    .job_flags     (job_flags),
    .job_len       (job_len),
    .job_start     (job_start),
    .job_pos       (job_pos)
  );

  dfr_queue #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({job_flags, job_len, job_start, job_pos}),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign {head_flags, head_len, head_start, head_pos} = head_data;

  dfr_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_flags (head_flags),
    .head_len   (head_len),
    .head_start (head_start),
    .head_pos   (head_pos),
    .pop        (pop),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .out_item   (result.payload)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for descending_fractional_rank_unit: streams column values,
// predicts each run's rank, length and column end, and checks every result in order.
// Depends on dfr_pkg, dfr_stream_if and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
  import dfr_pkg::*;

  localparam int VALUE_WIDTH    = 64;
  localparam int POSITION_WIDTH = 16;
  localparam logic [31:0] POS_MAX = 32'((64'd1 << POSITION_WIDTH) - 64'd1);
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);
  localparam int QUIET_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ROUNDS = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  dfr_stream_if #(.payload_t(in_item_t)) sample_if ();
  dfr_stream_if #(.payload_t(out_item_t)) result_if ();

  descending_fractional_rank_unit #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .POSITION_WIDTH(POSITION_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .sample(sample_if),
    .result(result_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Predictor state, mirroring the unit after each accepted value.
  logic [15:0] column_len;
  logic [63:0] last_value;
  logic [31:0] col_pos;
  logic [31:0] run_head;

  logic [63:0] pending_values[$];
  out_item_t   expected_runs[$];

  int errors = 0;
  int values_taken = 0;
  int runs_checked = 0;
  int length_settings = 0;
  int cycle_count = 0;
  int send_wait = 0;
  int recv_wait = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;

  initial begin
    sample_if.valid = 1'b0;
    sample_if.payload = '0;
    result_if.ready = 1'b0;
  end

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void push_run(logic [31:0] span, logic [31:0] first,
                                   logic [31:0] last, logic ends_column);
    out_item_t run;
    logic [31:0] twice_rank;
    twice_rank = 2 * span - first - last;
    run.rank_times_two = twice_rank[RANK_W-1:0];
    run.run_length = LEN_W'(last - first + 1);
    run.column_end = ends_column;
    expected_runs.push_back(run);
  endfunction

  function automatic void rank_value(logic [63:0] raw);
    logic [63:0] v;
    logic [31:0] p;
    logic [31:0] limit;
    logic [31:0] span;
    v = raw & VALUE_MASK;
    p = col_pos;
    limit = {16'h0, column_len};
    if (limit == 0) limit = 1;
    if (limit > POS_MAX) limit = POS_MAX;
    // A column cut short by a lowered length still ranks from its real size.
    span = (p + 1 > limit) ? p + 1 : limit;
    if (p == 0) begin
      run_head = 0;
    end else if (v != last_value) begin
      push_run(span, run_head, p - 1, 1'b0);
      run_head = p;
    end
    last_value = v;
    if (p + 1 >= limit) begin
      push_run(span, run_head, p, 1'b1);
      col_pos = 0;
      run_head = 0;
    end else begin
      col_pos = (p + 1) & POS_MAX;
    end
  endfunction

  // Value driver.
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      sample_if.payload <= '0;
      send_wait <= 0;
    end else if (!sample_if.valid || sample_if.ready) begin
      if (send_wait != 0) begin
        sample_if.valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_values.size() != 0) begin
        sample_if.valid <= 1'b1;
        sample_if.payload <= in_item_t'(pending_values.pop_front());
        send_wait <= send_steady ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0) send_steady <= !send_steady;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random back-pressure.
  always @(posedge clk) begin : receiver
    int unsigned stall;
    if (rst) begin
      result_if.ready <= 1'b0;
      recv_wait <= 0;
    end else if (recv_wait != 0) begin
      result_if.ready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else if (result_if.valid && result_if.ready) begin
      stall = recv_steady ? 0 : $urandom_range(0, 3);
      result_if.ready <= (stall == 0);
      recv_wait <= (stall == 0) ? 0 : stall - 1;
      if ($urandom_range(0, 47) == 0) recv_steady <= !recv_steady;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Monitor: predicts on accepted values, checks accepted results.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst) begin
      if (sample_if.valid && sample_if.ready) begin
        rank_value(sample_if.payload.value);
        values_taken++;
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_runs.size() == 0) begin
          errors++;
          if (errors <= 50) begin
            $display("%0t: unexpected run result: expected none", $time);
            $display("%0t:   got rank_times_two=%0d run_length=%0d column_end=%0d",
                     $time, result_if.payload.rank_times_two,
                     result_if.payload.run_length, result_if.payload.column_end);
          end
        end else begin
          want = expected_runs.pop_front();
          runs_checked++;
          if (want !== result_if.payload) begin
            errors++;
            if (errors <= 50) begin
              $display("%0t: run result mismatch: expected rank_times_two=%0d %s%0d %s%0d",
                       $time, want.rank_times_two, "run_length=", want.run_length,
                       "column_end=", want.column_end);
              $display("%0t:   got rank_times_two=%0d run_length=%0d column_end=%0d",
                       $time, result_if.payload.rank_times_two,
                       result_if.payload.run_length, result_if.payload.column_end);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d values pending and %0d results outstanding",
               $time, pending_values.size(), expected_runs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The upper half of pwdata is random: only the low 16 bits belong to the register.
  task automatic write_column_length(logic [15:0] len);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_COLUMN_LENGTH;
    pwdata <= {16'($urandom), len};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    column_len = len;
    length_settings++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every queued value is taken and every run result is back.
  task automatic drain_column_stream();
    while (pending_values.size() != 0 || sample_if.valid) @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Mostly runs of equal values; the rest is isolated noise.
  task automatic queue_value_runs(int count, int longest);
    logic [63:0] v;
    int reps;
    v = {$urandom, $urandom};
    while (count > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_values.push_back({$urandom, $urandom});
        count--;
      end else begin
        case ($urandom_range(0, 4))
          0: v = v ^ (64'd1 << $urandom_range(0, 63));
          1: v = ($urandom_range(0, 1) != 0) ? '0 : '1;
          2: v = {62'd0, 2'($urandom_range(0, 3))};
          default: v = {$urandom, $urandom};
        endcase
        reps = $urandom_range(1, longest);
        while (reps > 0 && count > 0) begin
          pending_values.push_back(v);
          reps--;
          count--;
        end
      end
    end
  endtask

  initial begin
    logic [15:0] len;
    column_len = COLUMN_LENGTH_RESET;
    last_value = '0;
    col_pos = 0;
    run_head = 0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset length of one: each value is a column by itself.
    pending_values.push_back(64'h0);
    pending_values.push_back('1);
    drain_column_stream();

    // A zero length behaves as one.
    write_column_length(16'd0);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'h8000_0000_0000_0000);
    drain_column_stream();

    // Tied pairs, a last value that closes two runs, and a column whose first value
    // matches the previous column's last one.
    write_column_length(16'd4);
    pending_values.push_back(64'h1);
    pending_values.push_back(64'h1);
    pending_values.push_back(64'h0);
    pending_values.push_back(64'h0);
    pending_values.push_back('1);
    pending_values.push_back(64'h7fff_ffff_ffff_ffff);
    pending_values.push_back(64'h7fff_ffff_ffff_ffff);
    pending_values.push_back(64'h0);
    repeat (4) pending_values.push_back(64'h0);
    drain_column_stream();

    // Longest column gives the top rank, then the length drops below the position.
    write_column_length(16'hffff);
    pending_values.push_back(64'h5a5a_5a5a_a5a5_a5a5);
    repeat (3) pending_values.push_back(64'h0123_4567_89ab_cdef);
    drain_column_stream();
    write_column_length(16'd2);
    pending_values.push_back(64'h0123_4567_89ab_cdef);
    pending_values.push_back(64'hfedc_ba98_7654_3210);
    pending_values.push_back(64'hfedc_ba98_7654_3210);
    drain_column_stream();

    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      if (round == 4) begin
        len = 16'hffff;
      end else if (round == 8) begin
        len = 16'd0;
      end else begin
        case ($urandom_range(0, 9))
          0: len = 16'd0;
          1: len = 16'd1;
          2: len = 16'd2;
          3, 4, 5: len = 16'($urandom_range(3, 12));
          6, 7: len = 16'($urandom_range(13, 64));
          8: len = 16'hffff;
          default: len = 16'($urandom_range(65, 65534));
        endcase
      end
      write_column_length(len);
      queue_value_runs($urandom_range(110, 150),
                       ($urandom_range(0, 3) == 0) ? 20 : 5);
      drain_column_stream();
    end

    repeat (20) @(posedge clk);
    if (expected_runs.size() != 0) begin
      errors++;
      $display("%0t: %0d run results never arrived", $time, expected_runs.size());
    end
    $display("Ranked %0d values under %0d column length settings; %0d run results checked.",
             values_taken, length_settings + 1, runs_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors found", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
